// File: rtl/seven_segment_scan_driver_unit_assert.svh
// Assertion macros for the seven-segment scan driver checker.
// No dependencies; included by the checker file.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ssd_pkg.sv
// Shared types, constants and the glyph lookup for the seven-segment scan driver.
// No dependencies.
package ssd_pkg;

    localparam int DIGIT_COUNT   = 4;
    localparam int CODE_W        = 4;
    localparam int FONT_W        = 64;
    localparam int SCANS_W       = 15;
    localparam int SEG_W         = 8;
    localparam int SEL_W         = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int NUM_DIGITS_DEF = 4;

    localparam logic [SEG_W-1:0] BLANK_SEGMENTS = 8'hFF;
    localparam logic [13:0]      DEC_MAX        = 14'd9999;
    localparam logic [13:0]      RECIP_1000     = 14'd8389;
    localparam int               SHIFT_1000     = 23;
    localparam logic [12:0]      RECIP_100      = 13'd5243;
    localparam int               SHIFT_100      = 19;
    localparam logic [15:0]      RECIP_10       = 16'd52429;
    localparam int               SHIFT_10       = 19;

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_LOAD_DEC = 2'd1,
        ACT_LOAD_HEX = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FONT_LOW  = 1'b0,
        CFG_FONT_HIGH = 1'b1
    } t_cfg_reg;

    typedef logic [DIGIT_COUNT-1:0][CODE_W-1:0] t_codes;

    typedef struct packed {
        t_codes             dec_codes;
        t_codes             hex_codes;
        logic [SCANS_W-1:0] hex_scans;
    } t_load;

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic [SEL_W-1:0] digit_select;
        logic             scanning;
    } t_result;

    function automatic logic [SEG_W-1:0] glyph_of(
        input logic [FONT_W-1:0] font_low,
        input logic [FONT_W-1:0] font_high,
        input logic [CODE_W-1:0] code
    );
        logic [FONT_W-1:0] bank;
        bank = code[3] ? font_high : font_low;
        return bank[{code[2:0], 3'b000} +: SEG_W];
    endfunction

endpackage

// File: rtl/ssd_digit_split.sv
// Splits a load value into four decimal and four hex digit codes, and the hex scan count.
// Depends on ssd_pkg.
module ssd_digit_split (
    input  logic [15:0]   i_value,
    input  logic [15:0]   i_scan_count,
    output ssd_pkg::t_load o_load
);
    import ssd_pkg::*;

    logic [13:0] w_sat;
    logic [27:0] w_p1000;
    logic [26:0] w_p100;
    logic [29:0] w_p10;
    logic [3:0]  w_q1000;
    logic [6:0]  w_q100;
    logic [9:0]  w_q10;
    logic [16:0] w_count_up;

    assign w_sat   = (i_value > 16'(DEC_MAX)) ? DEC_MAX : i_value[13:0];
    assign w_p1000 = 28'(w_sat) * 28'(RECIP_1000);
    assign w_p100  = 27'(w_sat) * 27'(RECIP_100);
    assign w_p10   = 30'(w_sat) * 30'(RECIP_10);
    assign w_q1000 = 4'(w_p1000 >> SHIFT_1000);
    assign w_q100  = 7'(w_p100 >> SHIFT_100);
    assign w_q10   = 10'(w_p10 >> SHIFT_10);

    always_comb begin
        o_load.dec_codes[0] = w_q1000;
        o_load.dec_codes[1] = 4'(w_q100 - 7'(w_q1000) * 7'd10);
        o_load.dec_codes[2] = 4'(w_q10 - 10'(w_q100) * 10'd10);
        o_load.dec_codes[3] = 4'(w_sat - 14'(w_q10) * 14'd10);
        o_load.hex_codes[0] = i_value[15:12];
        o_load.hex_codes[1] = i_value[11:8];
        o_load.hex_codes[2] = i_value[7:4];
        o_load.hex_codes[3] = i_value[3:0];
    end

    assign w_count_up       = 17'(i_scan_count) + 17'd3;
    assign o_load.hex_scans = w_count_up[16:2];

endmodule

// File: rtl/ssd_scan_core.sv
// Scan state (digit codes, phase, scans left, active flag) and per-transaction result.
// Depends on ssd_pkg.
module ssd_scan_core #(
    parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic [1:0]                  i_action,
    input  ssd_pkg::t_load              i_load,
    input  logic [ssd_pkg::FONT_W-1:0]  i_font_low,
    input  logic [ssd_pkg::FONT_W-1:0]  i_font_high,
    output ssd_pkg::t_result            o_result
);
    import ssd_pkg::*;

    localparam int PHASE_W = (2 * NUM_DIGITS > 2) ? $clog2(2 * NUM_DIGITS) : 1;
    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(2 * NUM_DIGITS - 1);

    t_codes             r_codes, n_codes;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [SCANS_W-1:0] r_scans, n_scans;
    logic               r_active, n_active;

    logic [PHASE_W-1:0] w_digit;
    logic [1:0]         w_code_idx;
    logic [SCANS_W-1:0] w_scans_dec;

    assign w_digit     = r_phase >> 1;
    assign w_code_idx  = 2'(w_digit);
    assign w_scans_dec = (r_scans != '0) ? r_scans - SCANS_W'(1) : r_scans;

    always_comb begin
        n_codes  = r_codes;
        n_phase  = r_phase;
        n_scans  = r_scans;
        n_active = r_active;
        o_result.segments     = BLANK_SEGMENTS;
        o_result.digit_select = '0;
        o_result.scanning     = r_active;
        case (t_action'(i_action))
            ACT_LOAD_DEC: begin
                n_codes  = i_load.dec_codes;
                n_phase  = '0;
                n_scans  = SCANS_W'(1);
                n_active = 1'b1;
                o_result.scanning = 1'b1;
            end
            ACT_LOAD_HEX: begin
                n_codes  = i_load.hex_codes;
                n_phase  = '0;
                n_scans  = i_load.hex_scans;
                n_active = (i_load.hex_scans != '0);
                o_result.scanning = (i_load.hex_scans != '0);
            end
            ACT_TICK: begin
                if (r_active) begin
                    if (r_phase[0]) begin
                        o_result.segments = glyph_of(i_font_low, i_font_high,
                                                     r_codes[w_code_idx]);
                        o_result.digit_select = (int'(w_digit) < SEL_W) ?
                                                (SEL_W'(1) << w_digit) : '0;
                    end
                    if (r_phase == LAST_PHASE) begin
                        n_phase  = '0;
                        n_scans  = w_scans_dec;
                        n_active = (w_scans_dec != '0);
                    end else begin
                        n_phase = r_phase + PHASE_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes  <= '0;
            r_phase  <= '0;
            r_scans  <= '0;
            r_active <= 1'b0;
        end else if (i_advance) begin
            r_codes  <= n_codes;
            r_phase  <= n_phase;
            r_scans  <= n_scans;
            r_active <= n_active;
        end
    end

endmodule

// File: rtl/seven_segment_scan_driver_unit.sv
// Top level of the seven-segment scan driver: input register, font registers, result register.
// Depends on ssd_pkg, ssd_digit_split and ssd_scan_core.
// A transaction goes from the input register, through the scan core, into the result register.
// Throughput: one transaction per cycle; while a result waits, one more transaction
// is taken into the input register, then input stalls.
// Reset (synchronous, active low) clears font registers, valid flags, digit codes and scan state.
module seven_segment_scan_driver_unit #(
    parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssd_pkg::FONT_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_action,
    input  logic [15:0]                    i_value,
    input  logic [15:0]                    i_scan_count,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ssd_pkg::SEG_W-1:0]      o_segments,
    output logic [ssd_pkg::SEL_W-1:0]      o_digit_select,
    output logic                           o_scanning
);
    import ssd_pkg::*;

    logic              r_in_valid;
    logic [1:0]        r_in_action;
    logic [15:0]       r_in_value;
    logic [15:0]       r_in_count;
    logic [FONT_W-1:0] r_font_low;
    logic [FONT_W-1:0] r_font_high;
    logic              r_out_valid;
    t_result           r_out;

    logic    w_advance;
    t_load   w_load;
    t_result w_result;

    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    ssd_digit_split u_split (
        .i_value      (r_in_value),
        .i_scan_count (r_in_count),
        .o_load       (w_load)
    );

    ssd_scan_core #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_action    (r_in_action),
        .i_load      (w_load),
        .i_font_low  (r_font_low),
        .i_font_high (r_font_high),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_low  <= '0;
            r_font_high <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_FONT_LOW:  r_font_low  <= i_cfg_data;
                CFG_FONT_HIGH: r_font_high <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_action <= i_action;
            r_in_value  <= i_value;
            r_in_count  <= i_scan_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_segments     = r_out.segments;
    assign o_digit_select = r_out.digit_select;
    assign o_scanning     = r_out.scanning;

endmodule

// File: rtl/ssd_checker.sv
// Port-level checker for the seven-segment scan driver, bound to the top level.
// Depends on ssd_pkg and seven_segment_scan_driver_unit_assert.svh.
`include "seven_segment_scan_driver_unit_assert.svh"

module ssd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [ssd_pkg::SEG_W-1:0] o_segments,
    input logic [ssd_pkg::SEL_W-1:0] o_digit_select,
    input logic                      o_scanning
);

    `SSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_segments) && $stable(o_digit_select) && $stable(o_scanning),
        "result changed while stalled")

    `SSD_ASSERT_NOW(a_sel_onehot, i_clk, i_rst_n, o_valid, $onehot0(o_digit_select),
        "more than one digit selected")

    `SSD_ASSERT_NOW(a_sel_scanning, i_clk, i_rst_n, o_valid && (o_digit_select != '0),
        o_scanning, "digit selected while not scanning")

endmodule

bind seven_segment_scan_driver_unit ssd_checker u_ssd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_segments     (o_segments),
    .o_digit_select (o_digit_select),
    .o_scanning     (o_scanning)
);
